### rtl/dhwc_pkg.sv
// Shared types and constants of the double hash word counter.
// Depends on nothing; used by rtl/double_hash_word_counter.sv and tb/testbench.sv.
`default_nettype none

package dhwc_pkg;

  // Port widths of the request and result fields
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 7;
  localparam int CNT_W  = 16;
  localparam int WORD_W = 16;

  // Polynomial hash base and character mapping
  localparam int            HASH_BASE    = 53;
  localparam int            CHAR_UPPER_A = 65;     // 'A'
  localparam logic [7:0]    CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0]    CHAR_LOWER_Z = 8'h7a;  // 'z'
  // lowercase adds c-'a'+26, i.e. (c - 6) - 'A'
  localparam logic [7:0]    LOWER_SHIFT  = 8'd6;

  // Request action codes
  localparam logic ACT_CHAR  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Result kind codes
  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_HQ     = 9'b000000100,
    S_HR     = 9'b000001000,
    S_HFIX   = 9'b000010000,
    S_ADDR   = 9'b000100000,
    S_READ   = 9'b001000000,
    S_MODIFY = 9'b010000000,
    S_SPARE  = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

### rtl/double_hash_word_counter.sv
// Double polynomial hash word counter: hashing, bucket store and sequencer.
// Depends on rtl/dhwc_pkg.sv.
`default_nettype none

// A request is taken when start is high and busy is low; busy stays high until
// the block can take the next one. A word character passes through the three
// steps of the modular hash unit (reciprocal multiply, multiply-subtract, final
// correction) before the next accept. The last character of a word adds the
// bucket address multiply and a read-modify-write of the count memory, whose
// read data is registered. A query passes through address, read and result.
// Each result appears on the out_ ports for exactly one cycle with out_valid
// high, in the same cycle in which busy falls; there is no backpressure, so the
// receiver must take it then. After reset the block clears the count memory
// one entry per cycle and holds busy high until every entry is cleared.
module double_hash_word_counter #(
  parameter int ROWS = 1013,
  parameter int COLS = 101
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_action,
  input  wire logic [dhwc_pkg::CHAR_W-1:0]  in_char_code,
  input  wire logic                         in_end_of_word,
  input  wire logic [dhwc_pkg::ROW_W-1:0]   in_row_index,
  input  wire logic [dhwc_pkg::COL_W-1:0]   in_col_index,
  // result channel
  output logic                              out_valid,
  output logic                              out_result_kind,
  output logic [dhwc_pkg::ROW_W-1:0]        out_bucket_row,
  output logic [dhwc_pkg::COL_W-1:0]        out_bucket_col,
  output logic [dhwc_pkg::CNT_W-1:0]        out_bucket_count,
  output logic [dhwc_pkg::WORD_W-1:0]       out_word_number,
  output logic                              out_is_maximum,
  output logic [dhwc_pkg::CNT_W-1:0]        out_max_count
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int HA_W   = $clog2(ROWS);
  localparam int HB_W   = $clog2(COLS);
  localparam int ROW_XW = (HA_W > dhwc_pkg::ROW_W) ? HA_W : dhwc_pkg::ROW_W;
  localparam int COL_XW = (HB_W > dhwc_pkg::COL_W) ? HB_W : dhwc_pkg::COL_W;
  localparam int MEM_W  = dhwc_pkg::CNT_W + dhwc_pkg::WORD_W;

  // Offset that makes h*53 + add nonnegative while keeping it mod-equivalent
  localparam int ZA_OFF = ROWS * ((dhwc_pkg::CHAR_UPPER_A + ROWS - 1) / ROWS)
                          - dhwc_pkg::CHAR_UPPER_A;
  localparam int ZB_OFF = COLS * ((dhwc_pkg::CHAR_UPPER_A + COLS - 1) / COLS)
                          - dhwc_pkg::CHAR_UPPER_A;
  localparam int ZA_MAX = (ROWS - 1) * dhwc_pkg::HASH_BASE + 255 + ZA_OFF;
  localparam int ZB_MAX = (COLS - 1) * dhwc_pkg::HASH_BASE + 255 + ZB_OFF;
  localparam int ZA_W   = $clog2(ZA_MAX + 1);
  localparam int ZB_W   = $clog2(ZB_MAX + 1);
  localparam int QA_W   = $clog2(ZA_MAX / ROWS + 1);
  localparam int QB_W   = $clog2(ZB_MAX / COLS + 1);
  // floor(2^ZW / m): quotient estimate is exact or one short
  localparam longint RECIP_A = (longint'(1) << ZA_W) / ROWS;
  localparam longint RECIP_B = (longint'(1) << ZB_W) / COLS;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  dhwc_pkg::state_t state_r, state_nxt;

  logic [HA_W-1:0]               hash_a_r, hash_a_nxt;
  logic [HB_W-1:0]               hash_b_r, hash_b_nxt;
  logic [dhwc_pkg::WORD_W-1:0]   word_ctr_r, word_ctr_nxt;
  logic [dhwc_pkg::CNT_W-1:0]    max_r, max_nxt;
  logic [ADDR_W-1:0]             clr_addr_r, clr_addr_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // payload registers
  logic                          kind_r, kind_nxt;
  logic                          eow_r, eow_nxt;
  logic [dhwc_pkg::ROW_W-1:0]    q_row_r, q_row_nxt;
  logic [dhwc_pkg::COL_W-1:0]    q_col_r, q_col_nxt;
  logic [ZA_W-1:0]               za_r, za_nxt;
  logic [ZB_W-1:0]               zb_r, zb_nxt;
  logic [QA_W-1:0]               qa_r, qa_nxt;
  logic [QB_W-1:0]               qb_r, qb_nxt;
  logic [HA_W:0]                 ra_r, ra_nxt;
  logic [HB_W:0]                 rb_r, rb_nxt;
  logic [ADDR_W-1:0]             addr_r, addr_nxt;
  logic                          in_range_r, in_range_nxt;
  logic [dhwc_pkg::ROW_W-1:0]    b_row_r, b_row_nxt;
  logic [dhwc_pkg::COL_W-1:0]    b_col_r, b_col_nxt;
  logic [MEM_W-1:0]              rd_data_r;

  logic                          o_kind_r, o_kind_nxt;
  logic [dhwc_pkg::ROW_W-1:0]    o_row_r, o_row_nxt;
  logic [dhwc_pkg::COL_W-1:0]    o_col_r, o_col_nxt;
  logic [dhwc_pkg::CNT_W-1:0]    o_count_r, o_count_nxt;
  logic [dhwc_pkg::WORD_W-1:0]   o_word_r, o_word_nxt;
  logic                          o_is_max_r, o_is_max_nxt;
  logic [dhwc_pkg::CNT_W-1:0]    o_max_r, o_max_nxt;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                          accept;
  logic                          is_lower;
  logic [7:0]                    add_off;
  logic [2*ZA_W-1:0]             prod_a;
  logic [2*ZB_W-1:0]             prod_b;
  logic [ROW_XW-1:0]             sel_row;
  logic [COL_XW-1:0]             sel_col;
  logic [dhwc_pkg::CNT_W-1:0]    rd_count;
  logic [dhwc_pkg::WORD_W-1:0]   rd_word;
  logic [dhwc_pkg::CNT_W-1:0]    inc_count;
  logic [dhwc_pkg::CNT_W-1:0]    inc_max;
  logic [dhwc_pkg::CNT_W-1:0]    qry_count;

  logic                          mem_we;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [MEM_W-1:0]              mem_wdata;

  assign busy   = (state_r != dhwc_pkg::S_IDLE);
  assign accept = start && !busy;

  // byte to addend, shifted up by 'A' so it stays nonnegative
  assign is_lower = (in_char_code >= dhwc_pkg::CHAR_LOWER_A) &&
                    (in_char_code <= dhwc_pkg::CHAR_LOWER_Z);
  assign add_off  = is_lower ? (in_char_code - dhwc_pkg::LOWER_SHIFT) : in_char_code;

  // reciprocal multiply of the hash unit
  assign prod_a = (2*ZA_W)'(za_r) * (2*ZA_W)'(RECIP_A);
  assign prod_b = (2*ZB_W)'(zb_r) * (2*ZB_W)'(RECIP_B);

  // bucket coordinates: query request or finished word hashes
  assign sel_row = (kind_r == dhwc_pkg::KIND_QUERY) ? ROW_XW'(q_row_r) : ROW_XW'(hash_a_r);
  assign sel_col = (kind_r == dhwc_pkg::KIND_QUERY) ? COL_XW'(q_col_r) : COL_XW'(hash_b_r);

  // read data split and updated count
  assign rd_count  = rd_data_r[MEM_W-1 -: dhwc_pkg::CNT_W];
  assign rd_word   = rd_data_r[dhwc_pkg::WORD_W-1:0];
  assign inc_count = (rd_count == '1) ? rd_count : rd_count + 1'b1;
  assign inc_max   = (inc_count > max_r) ? inc_count : max_r;
  assign qry_count = in_range_r ? rd_count : '0;

  // ---------------------------------------------------------------------------
  // Sequencer and datapath next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    hash_a_nxt    = hash_a_r;
    hash_b_nxt    = hash_b_r;
    word_ctr_nxt  = word_ctr_r;
    max_nxt       = max_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    kind_nxt      = kind_r;
    eow_nxt       = eow_r;
    q_row_nxt     = q_row_r;
    q_col_nxt     = q_col_r;
    za_nxt        = za_r;
    zb_nxt        = zb_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    addr_nxt      = addr_r;
    in_range_nxt  = in_range_r;
    b_row_nxt     = b_row_r;
    b_col_nxt     = b_col_r;
    o_kind_nxt    = o_kind_r;
    o_row_nxt     = o_row_r;
    o_col_nxt     = o_col_r;
    o_count_nxt   = o_count_r;
    o_word_nxt    = o_word_r;
    o_is_max_nxt  = o_is_max_r;
    o_max_nxt     = o_max_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = {inc_count, word_ctr_r};

    case (state_r)
      // sweep the count memory to zero after reset
      dhwc_pkg::S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = dhwc_pkg::S_IDLE;
        end
      end

      // take a request: query goes to addressing, a byte starts the hash unit
      dhwc_pkg::S_IDLE: begin
        if (accept) begin
          eow_nxt   = in_end_of_word;
          q_row_nxt = in_row_index;
          q_col_nxt = in_col_index;
          if (in_action == dhwc_pkg::ACT_QUERY) begin
            kind_nxt  = dhwc_pkg::KIND_QUERY;
            state_nxt = dhwc_pkg::S_ADDR;
          end else begin
            kind_nxt  = dhwc_pkg::KIND_WORD;
            za_nxt    = ZA_W'(ZA_W'(hash_a_r) * dhwc_pkg::HASH_BASE
                              + ZA_W'(add_off) + ZA_W'(ZA_OFF));
            zb_nxt    = ZB_W'(ZB_W'(hash_b_r) * dhwc_pkg::HASH_BASE
                              + ZB_W'(add_off) + ZB_W'(ZB_OFF));
            state_nxt = dhwc_pkg::S_HQ;
          end
        end
      end

      // quotient estimate
      dhwc_pkg::S_HQ: begin
        qa_nxt    = prod_a[ZA_W +: QA_W];
        qb_nxt    = prod_b[ZB_W +: QB_W];
        state_nxt = dhwc_pkg::S_HR;
      end

      // remainder, below twice the modulus
      dhwc_pkg::S_HR: begin
        ra_nxt    = (HA_W+1)'(za_r - ZA_W'(qa_r * ROWS));
        rb_nxt    = (HB_W+1)'(zb_r - ZB_W'(qb_r * COLS));
        state_nxt = dhwc_pkg::S_HFIX;
      end

      // final correction; the word ends here or waits for more bytes
      dhwc_pkg::S_HFIX: begin
        hash_a_nxt = (32'(ra_r) >= 32'(ROWS)) ? HA_W'(ra_r - (HA_W+1)'(ROWS)) : HA_W'(ra_r);
        hash_b_nxt = (32'(rb_r) >= 32'(COLS)) ? HB_W'(rb_r - (HB_W+1)'(COLS)) : HB_W'(rb_r);
        state_nxt  = eow_r ? dhwc_pkg::S_ADDR : dhwc_pkg::S_IDLE;
      end

      // flat bucket address
      dhwc_pkg::S_ADDR: begin
        addr_nxt     = ADDR_W'(32'(sel_row) * 32'(COLS) + 32'(sel_col));
        in_range_nxt = (kind_r == dhwc_pkg::KIND_WORD) ||
                       ((32'(q_row_r) < 32'(ROWS)) && (32'(q_col_r) < 32'(COLS)));
        b_row_nxt    = sel_row[dhwc_pkg::ROW_W-1:0];
        b_col_nxt    = sel_col[dhwc_pkg::COL_W-1:0];
        state_nxt    = dhwc_pkg::S_READ;
      end

      // memory read, data registered for next cycle
      dhwc_pkg::S_READ: begin
        mem_re    = in_range_r;
        state_nxt = dhwc_pkg::S_MODIFY;
      end

      // update the bucket or answer the query, then present the result
      dhwc_pkg::S_MODIFY: begin
        out_valid_nxt = 1'b1;
        o_kind_nxt    = kind_r;
        o_row_nxt     = b_row_r;
        o_col_nxt     = b_col_r;
        if (kind_r == dhwc_pkg::KIND_WORD) begin
          mem_we       = 1'b1;
          max_nxt      = inc_max;
          o_count_nxt  = inc_count;
          o_word_nxt   = word_ctr_r;
          o_is_max_nxt = (inc_count == inc_max);
          o_max_nxt    = inc_max;
          word_ctr_nxt = word_ctr_r + 1'b1;
          hash_a_nxt   = '0;
          hash_b_nxt   = '0;
        end else begin
          o_count_nxt  = qry_count;
          o_word_nxt   = (qry_count != '0) ? rd_word : '0;
          o_is_max_nxt = (qry_count != '0) && (qry_count == max_r);
          o_max_nxt    = max_r;
        end
        state_nxt = dhwc_pkg::S_IDLE;
      end

      default: begin
        state_nxt = dhwc_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dhwc_pkg::S_CLEAR;
      hash_a_r    <= '0;
      hash_b_r    <= '0;
      word_ctr_r  <= '0;
      max_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_a_r    <= hash_a_nxt;
      hash_b_r    <= hash_b_nxt;
      word_ctr_r  <= word_ctr_nxt;
      max_r       <= max_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    eow_r      <= eow_nxt;
    q_row_r    <= q_row_nxt;
    q_col_r    <= q_col_nxt;
    za_r       <= za_nxt;
    zb_r       <= zb_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    addr_r     <= addr_nxt;
    in_range_r <= in_range_nxt;
    b_row_r    <= b_row_nxt;
    b_col_r    <= b_col_nxt;
    o_kind_r   <= o_kind_nxt;
    o_row_r    <= o_row_nxt;
    o_col_r    <= o_col_nxt;
    o_count_r  <= o_count_nxt;
    o_word_r   <= o_word_nxt;
    o_is_max_r <= o_is_max_nxt;
    o_max_r    <= o_max_nxt;
  end

  // ---------------------------------------------------------------------------
  // Bucket memory: {count, word number} per bucket, one write and one read port
  // ---------------------------------------------------------------------------
  logic [MEM_W-1:0] bucket_mem [CELLS];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bucket_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= bucket_mem[addr_r];
    end
  end

  // result ports
  assign out_valid        = out_valid_r;
  assign out_result_kind  = o_kind_r;
  assign out_bucket_row   = o_row_r;
  assign out_bucket_col   = o_col_r;
  assign out_bucket_count = o_count_r;
  assign out_word_number  = o_word_r;
  assign out_is_maximum   = o_is_max_r;
  assign out_max_count    = o_max_r;

`ifndef SYNTHESIS
  // a result only follows the read-modify-write step
  a_out_after_modify: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == dhwc_pkg::S_MODIFY))
    else $error("result strobe without a preceding modify step");

  // running maximum never drops
  a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (max_r >= $past(max_r)))
    else $error("running maximum decreased");

  // word hashes stay reduced
  a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(hash_a_r) < 32'(ROWS)) && (32'(hash_b_r) < 32'(COLS)))
    else $error("hash out of range");

  // an inserted word always reports a nonzero count within the maximum
  a_word_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == dhwc_pkg::KIND_WORD)) |->
      ((out_bucket_count != '0) && (out_max_count >= out_bucket_count)))
    else $error("bad word insert report");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for double_hash_word_counter: directed table, random words and queries.
// Depends on rtl/dhwc_pkg.sv and rtl/double_hash_word_counter.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS             = 1013;
  localparam int COLS             = 101;
  localparam int LOWER_OFFSET     = 26;       // 'a' maps to 26
  localparam int VOCAB_SIZE       = 12;
  localparam int MAX_WORD_LEN     = 8;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int DRAIN_CYCLES     = 16;
  localparam int PRINT_CAP        = 40;
  // covers the clear pass and the random words and queries
  localparam int LIMIT_CYCLES     = 500000;

  typedef struct packed {
    logic                        action;
    logic [dhwc_pkg::CHAR_W-1:0] char_code;
    logic                        end_of_word;
    logic [dhwc_pkg::ROW_W-1:0]  row;
    logic [dhwc_pkg::COL_W-1:0]  col;
  } request_t;

  typedef struct packed {
    logic                        kind;
    logic [dhwc_pkg::ROW_W-1:0]  row;
    logic [dhwc_pkg::COL_W-1:0]  col;
    logic [dhwc_pkg::CNT_W-1:0]  count;
    logic [dhwc_pkg::WORD_W-1:0] word;
    logic                        is_max;
    logic [dhwc_pkg::CNT_W-1:0]  max_count;
  } bucket_report_t;

  typedef struct packed {
    request_t       req;
    logic           has_answer;
    bucket_report_t answer;
  } directed_row_t;

  localparam bucket_report_t NO_ANSWER = '0;

  // Directed requests; answers typed in where they follow directly from reset
  localparam int DIRECTED_COUNT = 22;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // 'A' alone hashes to bucket (0,0): first word ever
    '{'{dhwc_pkg::ACT_CHAR, 8'h41, 1'b1, 10'd0, 7'd0}, 1'b1,
      '{dhwc_pkg::KIND_WORD, 10'd0, 7'd0, 16'd1, 16'd0, 1'b1, 16'd1}},
    '{'{dhwc_pkg::ACT_QUERY, 8'h00, 1'b0, 10'd0, 7'd0}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd0, 7'd0, 16'd1, 16'd0, 1'b1, 16'd1}},
    // '@' adds -1: negative remainder lands on the last bucket
    '{'{dhwc_pkg::ACT_CHAR, 8'h40, 1'b1, 10'd0, 7'd0}, 1'b1,
      '{dhwc_pkg::KIND_WORD, 10'd1012, 7'd100, 16'd1, 16'd1, 1'b1, 16'd1}},
    '{'{dhwc_pkg::ACT_QUERY, 8'h00, 1'b0, 10'd1012, 7'd100}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd1012, 7'd100, 16'd1, 16'd1, 1'b1, 16'd1}},
    // out-of-range queries
    '{'{dhwc_pkg::ACT_QUERY, 8'h00, 1'b0, 10'd1023, 7'd127}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd1023, 7'd127, 16'd0, 16'd0, 1'b0, 16'd1}},
    '{'{dhwc_pkg::ACT_QUERY, 8'h00, 1'b0, 10'd1013, 7'd0}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd1013, 7'd0, 16'd0, 16'd0, 1'b0, 16'd1}},
    '{'{dhwc_pkg::ACT_QUERY, 8'h00, 1'b0, 10'd0, 7'd101}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd0, 7'd101, 16'd0, 16'd0, 1'b0, 16'd1}},
    // repeat of 'A' raises the maximum; the '@' bucket is no longer the max
    '{'{dhwc_pkg::ACT_CHAR, 8'h41, 1'b1, 10'd0, 7'd0}, 1'b1,
      '{dhwc_pkg::KIND_WORD, 10'd0, 7'd0, 16'd2, 16'd2, 1'b1, 16'd2}},
    '{'{dhwc_pkg::ACT_QUERY, 8'h00, 1'b0, 10'd1012, 7'd100}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd1012, 7'd100, 16'd1, 16'd1, 1'b0, 16'd2}},
    // byte extremes and letter boundaries
    '{'{dhwc_pkg::ACT_CHAR, 8'h00, 1'b0, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_CHAR, 8'hFF, 1'b1, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_CHAR, 8'h61, 1'b0, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_CHAR, 8'h7A, 1'b0, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_CHAR, 8'h5A, 1'b0, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_CHAR, 8'h60, 1'b0, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_CHAR, 8'h7B, 1'b0, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_CHAR, 8'h80, 1'b1, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    // unused fields all ones must be ignored
    '{'{dhwc_pkg::ACT_CHAR, 8'h41, 1'b1, 10'h3FF, 7'h7F}, 1'b1,
      '{dhwc_pkg::KIND_WORD, 10'd0, 7'd0, 16'd3, 16'd5, 1'b1, 16'd3}},
    '{'{dhwc_pkg::ACT_QUERY, 8'hFF, 1'b1, 10'd0, 7'd0}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd0, 7'd0, 16'd3, 16'd5, 1'b1, 16'd3}},
    // query in the middle of a word leaves the hashes alone
    '{'{dhwc_pkg::ACT_CHAR, 8'h71, 1'b0, 10'd0, 7'd0}, 1'b0, NO_ANSWER},
    '{'{dhwc_pkg::ACT_QUERY, 8'h00, 1'b0, 10'd0, 7'd0}, 1'b1,
      '{dhwc_pkg::KIND_QUERY, 10'd0, 7'd0, 16'd3, 16'd5, 1'b1, 16'd3}},
    '{'{dhwc_pkg::ACT_CHAR, 8'h71, 1'b1, 10'd0, 7'd0}, 1'b0, NO_ANSWER}
  };

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        start          = 1'b0;
  logic                        in_action      = 1'b0;
  logic [dhwc_pkg::CHAR_W-1:0] in_char_code   = '0;
  logic                        in_end_of_word = 1'b0;
  logic [dhwc_pkg::ROW_W-1:0]  in_row_index   = '0;
  logic [dhwc_pkg::COL_W-1:0]  in_col_index   = '0;
  logic                        busy;
  logic                        out_valid;
  logic                        out_result_kind;
  logic [dhwc_pkg::ROW_W-1:0]  out_bucket_row;
  logic [dhwc_pkg::COL_W-1:0]  out_bucket_col;
  logic [dhwc_pkg::CNT_W-1:0]  out_bucket_count;
  logic [dhwc_pkg::WORD_W-1:0] out_word_number;
  logic                        out_is_maximum;
  logic [dhwc_pkg::CNT_W-1:0]  out_max_count;

  double_hash_word_counter #(.ROWS(ROWS), .COLS(COLS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_char_code     (in_char_code),
    .in_end_of_word   (in_end_of_word),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_bucket_row   (out_bucket_row),
    .out_bucket_col   (out_bucket_col),
    .out_bucket_count (out_bucket_count),
    .out_word_number  (out_word_number),
    .out_is_maximum   (out_is_maximum),
    .out_max_count    (out_max_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: running hashes, per-bucket counts and last word numbers
  int                          hash_row;
  int                          hash_col;
  bit [dhwc_pkg::CNT_W-1:0]    tally [ROWS*COLS];
  bit [dhwc_pkg::WORD_W-1:0]   last_word [ROWS*COLS];
  bit [dhwc_pkg::WORD_W-1:0]   word_seq;
  bit [dhwc_pkg::CNT_W-1:0]    peak;
  int                          filled_buckets [$];   // buckets with a nonzero count

  bucket_report_t              pending_reports [$];
  int                          mismatch_count;
  int                          requests_sent;
  int                          idle_pct;
  int                          cycle_count;
  int                          phase_idle [3] = '{0, 61, 21};
  logic [7:0]                  vocab_text [VOCAB_SIZE][MAX_WORD_LEN];
  int                          vocab_len [VOCAB_SIZE];

  function automatic int mod_step(input int h, input int add, input int m);
    int r;
    r = (h * dhwc_pkg::HASH_BASE + add) % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic bucket_report_t make_report(input logic kind, input int row, input int col,
                                                 input bit [dhwc_pkg::CNT_W-1:0] cnt,
                                                 input bit [dhwc_pkg::WORD_W-1:0] wnum);
    bucket_report_t rep;
    rep.kind      = kind;
    rep.row       = dhwc_pkg::ROW_W'(row);
    rep.col       = dhwc_pkg::COL_W'(col);
    rep.count     = cnt;
    rep.word      = (cnt != 0) ? wnum : '0;
    rep.is_max    = (cnt != 0) && (cnt == peak);
    rep.max_count = peak;
    return rep;
  endfunction

  // Advance the model by one request; returns 1 when a report is due
  function automatic bit predict_bucket(input request_t req, output bucket_report_t rep);
    int                       add;
    int                       idx;
    bit [dhwc_pkg::CNT_W-1:0] cnt;
    rep = '0;
    if (req.action == dhwc_pkg::ACT_QUERY) begin
      cnt = '0;
      idx = 0;
      if (req.row < ROWS && req.col < COLS) begin
        idx = req.row * COLS + req.col;
        cnt = tally[idx];
      end
      rep = make_report(dhwc_pkg::KIND_QUERY, int'(req.row), int'(req.col), cnt,
                        last_word[idx]);
      return 1'b1;
    end
    if (req.char_code >= dhwc_pkg::CHAR_LOWER_A && req.char_code <= dhwc_pkg::CHAR_LOWER_Z)
      add = int'(req.char_code) - int'(dhwc_pkg::CHAR_LOWER_A) + LOWER_OFFSET;
    else
      add = int'(req.char_code) - dhwc_pkg::CHAR_UPPER_A;
    hash_row = mod_step(hash_row, add, ROWS);
    hash_col = mod_step(hash_col, add, COLS);
    if (!req.end_of_word) return 1'b0;
    // last byte: bump the bucket, saturating
    idx = hash_row * COLS + hash_col;
    cnt = tally[idx];
    if (cnt == 0) filled_buckets.push_back(idx);
    if (cnt != '1) cnt++;
    tally[idx]     = cnt;
    last_word[idx] = word_seq;
    if (cnt > peak) peak = cnt;
    rep = make_report(dhwc_pkg::KIND_WORD, hash_row, hash_col, cnt, word_seq);
    word_seq++;
    hash_row = 0;
    hash_col = 0;
    return 1'b1;
  endfunction

  // Drive one request, wait for the handshake, then idle at random
  task automatic issue(input request_t req, input bit use_answer, input bucket_report_t answer);
    bucket_report_t predicted;
    in_action      <= req.action;
    in_char_code   <= req.char_code;
    in_end_of_word <= req.end_of_word;
    in_row_index   <= req.row;
    in_col_index   <= req.col;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    requests_sent++;
    if (predict_bucket(req, predicted))
      pending_reports.push_back(use_answer ? answer : predicted);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic eow);
    request_t req;
    req = '{dhwc_pkg::ACT_CHAR, c, eow, dhwc_pkg::ROW_W'($urandom_range(1023)),
            dhwc_pkg::COL_W'($urandom_range(127))};
    issue(req, 1'b0, NO_ANSWER);
  endtask

  task automatic send_query(input int row, input int col);
    request_t req;
    req = '{dhwc_pkg::ACT_QUERY, dhwc_pkg::CHAR_W'($urandom_range(255)),
            1'($urandom_range(1)), dhwc_pkg::ROW_W'(row), dhwc_pkg::COL_W'(col)};
    issue(req, 1'b0, NO_ANSWER);
  endtask

  // Mostly buckets already written, some anywhere in range (mostly empty), the rest out of range
  task automatic query_somewhere();
    int k;
    int idx;
    k = $urandom_range(9);
    if (k < 6 && filled_buckets.size() > 0) begin
      idx = filled_buckets[$urandom_range(filled_buckets.size() - 1)];
      send_query(idx / COLS, idx % COLS);
    end else if (k < 7)
      send_query($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
    else if (k == 7)
      send_query($urandom_range(1023, ROWS), $urandom_range(127));
    else if (k == 8)
      send_query($urandom_range(1023), $urandom_range(127, COLS));
    else
      send_query($urandom_range(1023, ROWS), $urandom_range(127, COLS));
  endtask

  function automatic logic [7:0] word_byte();
    int k;
    k = $urandom_range(9);
    if (k < 5) return 8'h61 + 8'($urandom_range(25));
    if (k < 8) return 8'h41 + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_vocab_word(input int w);
    for (int i = 0; i < vocab_len[w]; i++) begin
      // now and then a query lands inside the word
      if (i > 0 && $urandom_range(19) == 0) query_somewhere();
      send_char(vocab_text[w][i], i == vocab_len[w] - 1);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      if (mismatch_count < PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every strobed result against the oldest expectation
  always @(posedge clk) begin
    bucket_report_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_reports.size() == 0) begin
        if (mismatch_count < PRINT_CAP)
          $display("%0t: unexpected result, expected none, actual row %0d col %0d",
                   $time, out_bucket_row, out_bucket_col);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("result_kind", 32'(want.kind), 32'(out_result_kind));
        compare_field("bucket_row", 32'(want.row), 32'(out_bucket_row));
        compare_field("bucket_col", 32'(want.col), 32'(out_bucket_col));
        compare_field("bucket_count", 32'(want.count), 32'(out_bucket_count));
        compare_field("word_number", 32'(want.word), 32'(out_word_number));
        compare_field("is_maximum", 32'(want.is_max), 32'(out_is_maximum));
        compare_field("max_count", 32'(want.max_count), 32'(out_max_count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int k;
    int len;
    repeat (5) @(posedge clk);
    rst_n    <= 1'b1;
    idle_pct = 0;

    // directed table
    foreach (DIRECTED_ROWS[i])
      issue(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].has_answer, DIRECTED_ROWS[i].answer);

    // small vocabulary so words repeat and counts climb
    for (int w = 0; w < VOCAB_SIZE; w++) begin
      vocab_len[w] = ($urandom_range(3) == 0) ? $urandom_range(5, MAX_WORD_LEN)
                                              : $urandom_range(1, 4);
      for (int i = 0; i < MAX_WORD_LEN; i++) vocab_text[w][i] = word_byte();
    end

    // random words, fresh words, queries and stray bytes, one idle setting per phase
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase_idle[phase];
      while (requests_sent < DIRECTED_COUNT + (phase + 1) * RANDOM_PER_PHASE) begin
        k = $urandom_range(99);
        if (k < 55)
          send_vocab_word($urandom_range(VOCAB_SIZE - 1));
        else if (k < 70) begin
          len = $urandom_range(1, MAX_WORD_LEN);
          for (int i = 0; i < len; i++) send_char(word_byte(), i == len - 1);
        end else if (k < 90)
          query_somewhere();
        else
          send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end

    // a last few queries with no idling
    idle_pct = 0;
    send_query(0, 0);
    repeat (4) query_somewhere();

    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### double_hash_word_counter.f
rtl/dhwc_pkg.sv
rtl/double_hash_word_counter.sv
tb/testbench.sv
